/* src/fast_tree_key_search_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the fast tree key search unit
// Checks sample on the rising edge of clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FAST_TREE_KEY_SEARCH_UNIT_MACROS_SVH
`define FAST_TREE_KEY_SEARCH_UNIT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define FTKS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftks: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FTKS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftks: next-cycle check failed");

`else

`define FTKS_ASSERT_NOW(name, ante, cons)
`define FTKS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

/* src/ftks_pkg.sv */
// ----------------------------------------------------------------------------
// ftks_pkg
// Types and fixed constants shared by the tree key search modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ftks_pkg;

    localparam int KEY_W       = 32;
    localparam int ADDR_W      = 13;
    localparam int LEAF_W      = 12;
    localparam int LANE_W      = 4;
    localparam int BLOCK_WORDS = 16;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [ADDR_W-1:0]        word_address;
        logic signed [KEY_W-1:0]  word_value;
        logic signed [KEY_W-1:0]  query_key;
    } req_item_t;

    typedef struct packed {
        logic [LEAF_W-1:0] leaf_index;
        logic              fault;
    } rsp_item_t;

    // One tree block: sixteen key words, lane 0 in the low bits.
    typedef logic [BLOCK_WORDS-1:0][KEY_W-1:0] block_t;

    typedef struct packed {
        logic [LANE_W-1:0] child;
        logic              fault;
    } node_result_t;

endpackage

`default_nettype wire

/* src/ftks_tree_store.sv */
// ----------------------------------------------------------------------------
// ftks_tree_store
// Tree word store organised as one block per row: single-word writes into
// one lane, whole-block reads with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ftks_tree_store #(
    parameter int ROW_W = 9
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [ROW_W-1:0]                 wr_row,
    input  wire logic [ftks_pkg::LANE_W-1:0]      wr_lane,
    input  wire logic [ftks_pkg::KEY_W-1:0]       wr_word,
    input  wire logic                             rd_en,
    input  wire logic [ROW_W-1:0]                 rd_row,
    output ftks_pkg::block_t                      rd_block
);

    localparam int ROWS = 1 << ROW_W;

    ftks_pkg::block_t mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row][wr_lane] <= wr_word;
        end
        if (rd_en)
        begin
            rd_block <= mem[rd_row];
        end
    end

endmodule

`default_nettype wire

/* src/ftks_node_cmp.sv */
// ----------------------------------------------------------------------------
// ftks_node_cmp
// Evaluates one tree block against the search key: the first three-key group
// picks a subgroup, the selected second group picks the child within it.
// ----------------------------------------------------------------------------
`default_nettype none

module ftks_node_cmp (
    input  wire logic signed [ftks_pkg::KEY_W-1:0] key,
    input  wire ftks_pkg::block_t                  blk,
    output ftks_pkg::node_result_t                 res
);

    localparam int GROUPS = 5;

    // Compare patterns: bit 0 against the median, bit 1 the left median,
    // bit 2 the right median.
    localparam logic [2:0] PAT_CHILD0 = 3'b000;
    localparam logic [2:0] PAT_CHILD1 = 3'b010;
    localparam logic [2:0] PAT_CHILD2 = 3'b011;
    localparam logic [2:0] PAT_CHILD3 = 3'b111;

    // Returns {bad, child}; a pattern that ordered keys cannot give walks
    // on as the rightmost child.
    function automatic logic [2:0] group_child(input logic [2:0] pat);
        logic [2:0] r;
        case (pat)
            PAT_CHILD0: r = {1'b0, 2'd0};
            PAT_CHILD1: r = {1'b0, 2'd1};
            PAT_CHILD2: r = {1'b0, 2'd2};
            PAT_CHILD3: r = {1'b0, 2'd3};
            default:    r = {1'b1, 2'd3};
        endcase
        return r;
    endfunction

    logic [2:0] pat [GROUPS];
    logic [2:0] first;
    logic [2:0] second;

    // All five groups are compared at once; the second stage only selects.
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            pat[g] = {key > $signed(blk[3*g+2]),
                      key > $signed(blk[3*g+1]),
                      key > $signed(blk[3*g])};
        end
        first     = group_child(pat[0]);
        second    = group_child(pat[3'(first[1:0]) + 3'd1]);
        res.child = {first[1:0], second[1:0]};
        res.fault = first[2] | second[2];
    end

endmodule

`default_nettype wire

/* src/fast_tree_key_search_unit.sv */
// ----------------------------------------------------------------------------
// fast_tree_key_search_unit
// A write item stores one signed key word at word_address; a search item
// walks TOP_LEVELS levels of the top page and LOWER_LEVELS levels of the
// lower page chosen by the top walk, and returns the leaf index (the chosen
// children, four bits per level, low 12 bits kept) with a fault flag that is
// set, and the leaf forced to zero, when any group compare gave an
// impossible pattern. Writes give no result item. No new item is accepted
// while a search is under way or while its result waits for the output slot.
// Each level issues one whole-block read of the tree store and evaluates the
// returned block in the following cycle, so the single read port of the
// store sets the pace. STORE_DEPTH must be a power of two; read addresses
// wrap at STORE_DEPTH, writes at or above it are dropped, and the store
// holds at most 8192 words. A tree word must be written before any search
// reads it; the store is not cleared at reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fast_tree_key_search_unit_macros.svh"

module fast_tree_key_search_unit #(
    parameter int TOP_LEVELS   = 2,
    parameter int LOWER_LEVELS = 1,
    parameter int STORE_DEPTH  = 8192
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire ftks_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output ftks_pkg::rsp_item_t     rsp
);

    localparam int LANE_W = ftks_pkg::LANE_W;
    localparam int LEAF_W = ftks_pkg::LEAF_W;
    localparam int ADDR_W = ftks_pkg::ADDR_W;
    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int MEM_AW = (AW < ADDR_W) ? AW : ADDR_W;
    localparam int MRW    = MEM_AW - LANE_W;
    localparam int CMP_W  = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
    localparam int LVL_W  = 2;

    localparam logic PAGE_TOP   = 1'b0;
    localparam logic PAGE_LOWER = 1'b1;

    // Rows (blocks) in a page of the given number of levels.
    function automatic int rows_of(input int levels);
        int acc;
        acc = 0;
        for (int i = 0; i < levels; i++)
        begin
            acc += 1 << (LANE_W * i);
        end
        return acc;
    endfunction

    localparam logic [MRW-1:0] TOP_ROWS = MRW'(rows_of(TOP_LEVELS));
    localparam logic [MRW-1:0] LOW_ROWS = MRW'(rows_of(LOWER_LEVELS));
    localparam logic [MRW-1:0] LVL_OFF [4] = '{MRW'(rows_of(0)), MRW'(rows_of(1)),
                                               MRW'(rows_of(2)), MRW'(rows_of(3))};

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic                            page_reg, page_next;
    logic [LVL_W-1:0]                lvl_reg, lvl_next;
    logic [MRW-1:0]                  base_reg, base_next;
    logic [MRW-1:0]                  node_reg, node_next;
    logic [LEAF_W-1:0]               path_reg, path_next;
    logic                            fault_reg, fault_next;
    logic signed [ftks_pkg::KEY_W-1:0] key_reg, key_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    ftks_pkg::rsp_item_t             rsp_reg, rsp_next;

    logic                            wr_en;
    logic                            rd_en;
    logic [MRW-1:0]                  rd_row;
    ftks_pkg::block_t                rd_block;
    ftks_pkg::node_result_t          res;
    logic [MRW-1:0]                  node_ext;
    logic [LEAF_W-1:0]               path_ext;
    logic                            fault_ext;
    logic                            level_last;
    logic                            slot_free;
    logic                            out_load;
    logic                            req_fire;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign wr_en     = req_fire && (req.command == ftks_pkg::CMD_WRITE)
                       && (CMP_W'(req.word_address) < CMP_W'(STORE_DEPTH));

    assign rd_en  = (state_reg == ST_READ);
    assign rd_row = base_reg + LVL_OFF[lvl_reg] + node_reg;

    ftks_tree_store #(
        .ROW_W (MRW)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_row   (req.word_address[MEM_AW-1:LANE_W]),
        .wr_lane  (req.word_address[LANE_W-1:0]),
        .wr_word  (req.word_value),
        .rd_en    (rd_en),
        .rd_row   (rd_row),
        .rd_block (rd_block)
    );

    ftks_node_cmp u_cmp (
        .key (key_reg),
        .blk (rd_block),
        .res (res)
    );

    assign node_ext   = {node_reg[MRW-LANE_W-1:0], res.child};
    assign path_ext   = {path_reg[LEAF_W-LANE_W-1:0], res.child};
    assign fault_ext  = fault_reg | res.fault;
    assign level_last = (page_reg == PAGE_LOWER) ? (lvl_reg == LVL_W'(LOWER_LEVELS - 1))
                                                 : (lvl_reg == LVL_W'(TOP_LEVELS - 1));
    assign slot_free  = !rsp_valid_reg || rsp_ready;
    assign out_load   = slot_free
                        && (((state_reg == ST_EVAL) && level_last && (page_reg == PAGE_LOWER))
                            || (state_reg == ST_DONE));

    always_comb
    begin
        state_next = state_reg;
        page_next  = page_reg;
        lvl_next   = lvl_reg;
        base_next  = base_reg;
        node_next  = node_reg;
        path_next  = path_reg;
        fault_next = fault_reg;
        key_next   = key_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.command == ftks_pkg::CMD_SEARCH))
                begin
                    key_next   = req.query_key;
                    page_next  = PAGE_TOP;
                    lvl_next   = '0;
                    base_next  = '0;
                    node_next  = '0;
                    path_next  = '0;
                    fault_next = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                path_next  = path_ext;
                fault_next = fault_ext;
                if (!level_last)
                begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    node_next  = node_ext;
                    state_next = ST_READ;
                end
                else if (page_reg == PAGE_TOP)
                begin
                    // The lower page sits after the top page, one page per top leaf.
                    page_next  = PAGE_LOWER;
                    lvl_next   = '0;
                    node_next  = '0;
                    base_next  = TOP_ROWS + MRW'(node_ext * LOW_ROWS);
                    state_next = ST_READ;
                end
                else if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic             f;
        logic [LEAF_W-1:0] p;
        f = (state_reg == ST_EVAL) ? fault_ext : fault_reg;
        p = (state_reg == ST_EVAL) ? path_ext : path_reg;
        rsp_next.fault      = f;
        rsp_next.leaf_index = f ? '0 : p;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            page_reg      <= PAGE_TOP;
            lvl_reg       <= '0;
            fault_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            page_reg      <= page_next;
            lvl_reg       <= lvl_next;
            fault_reg     <= fault_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        node_reg <= node_next;
        path_reg <= path_next;
        key_reg  <= key_next;
        if (out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A search item starts its first block read in the next cycle.
    `FTKS_ASSERT_NEXT(a_search_reads, req_fire && (req.command == ftks_pkg::CMD_SEARCH), rd_en)
    // The store never sees a write while a search reads it.
    `FTKS_ASSERT_NOW(a_no_rw_overlap, rd_en, !wr_en)
    // A faulty walk never reports a leaf.
    `FTKS_ASSERT_NOW(a_fault_leaf, rsp_valid && rsp.fault, rsp.leaf_index == '0)
    // The level counter stays inside the top page.
    `FTKS_ASSERT_NOW(a_top_level, (state_reg == ST_EVAL) && (page_reg == PAGE_TOP),
                     lvl_reg <= LVL_W'(TOP_LEVELS - 1))

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the fast tree key search unit
// Before each search, every three-key group on the key's path that is not yet
// fully written is loaded with sorted keys. A short table of probes (extreme
// keys, each impossible compare pattern at the root, keys equal to node
// values) is followed by a long random mix of searches, sorted group rewrites
// and stray word writes. Every search result is checked, typed probes against
// the table and the rest against a shadow copy of the tree walked in the
// testbench, with random idling on both sides and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb;

    localparam int TOP_LEVELS       = 2;
    localparam int LOWER_LEVELS     = 1;
    localparam int STORE_DEPTH      = 8192;
    localparam int TOP_PAGE_WORDS   =
        ftks_pkg::BLOCK_WORDS * ((1 << (4 * TOP_LEVELS)) - 1) / 15;
    localparam int LOWER_PAGE_WORDS =
        ftks_pkg::BLOCK_WORDS * ((1 << (4 * LOWER_LEVELS)) - 1) / 15;
    localparam int TREE_WORDS       = TOP_PAGE_WORDS
                                      + (1 << (4 * TOP_LEVELS)) * LOWER_PAGE_WORDS;
    localparam int ITEM_COUNT       = 850;
    localparam int HOLD_AFTER       = 40;
    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 30;

    localparam logic signed [ftks_pkg::KEY_W-1:0] KEY_MAX =
        {1'b0, {(ftks_pkg::KEY_W-1){1'b1}}};
    localparam logic signed [ftks_pkg::KEY_W-1:0] KEY_MIN =
        {1'b1, {(ftks_pkg::KEY_W-1){1'b0}}};

    // Compare patterns of one group: bit 0 median, bit 1 left, bit 2 right.
    localparam logic [2:0] BELOW_ALL    = 3'b000;
    localparam logic [2:0] ABOVE_LEFT   = 3'b010;
    localparam logic [2:0] ABOVE_MEDIAN = 3'b011;
    localparam logic [2:0] ABOVE_ALL    = 3'b111;

    typedef struct packed {
        logic                        command;
        logic [ftks_pkg::ADDR_W-1:0] addr;
        logic [ftks_pkg::KEY_W-1:0]  value;
        logic                        typed;
        logic [ftks_pkg::LEAF_W-1:0] leaf;
        logic                        fault;
    } probe_row_t;

    localparam probe_row_t PROBES [21] = '{
        '{ftks_pkg::CMD_SEARCH, 13'd0, KEY_MIN,      1'b1, 12'd0,    1'b0},
        '{ftks_pkg::CMD_SEARCH, 13'd0, KEY_MAX,      1'b1, 12'hFFF,  1'b0},
        '{ftks_pkg::CMD_WRITE,  13'd0, -32'sd5,      1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_WRITE,  13'd1, 32'sd10,      1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_WRITE,  13'd2, 32'sd10,      1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_SEARCH, 13'd0, 32'sd0,       1'b1, 12'd0,    1'b1},
        '{ftks_pkg::CMD_WRITE,  13'd2, -32'sd5,      1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_SEARCH, 13'd0, 32'sd0,       1'b1, 12'd0,    1'b1},
        '{ftks_pkg::CMD_WRITE,  13'd0, 32'sd10,      1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_WRITE,  13'd1, -32'sd5,      1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_SEARCH, 13'd0, 32'sd0,       1'b1, 12'd0,    1'b1},
        '{ftks_pkg::CMD_WRITE,  13'd1, 32'sd10,      1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_SEARCH, 13'd0, 32'sd0,       1'b1, 12'd0,    1'b1},
        '{ftks_pkg::CMD_WRITE,  13'd0, 32'sd0,       1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_WRITE,  13'd1, -32'sd1000,   1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_WRITE,  13'd2, 32'sd1000,    1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_SEARCH, 13'd0, -32'sd1000,   1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_SEARCH, 13'd0, 32'sd0,       1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_SEARCH, 13'd0, 32'sd1000,    1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_SEARCH, 13'd0, 32'sd1001,    1'b0, 12'd0,    1'b0},
        '{ftks_pkg::CMD_SEARCH, 13'd0, -32'sd999,    1'b0, 12'd0,    1'b0}
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    ftks_pkg::req_item_t req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    ftks_pkg::rsp_item_t rsp;

    logic signed [ftks_pkg::KEY_W-1:0] tree_shadow [STORE_DEPTH];
    bit                                tree_written [STORE_DEPTH];
    ftks_pkg::rsp_item_t               pending_leaves [$];
    int                                fails        = 0;
    int                                leaves_seen  = 0;
    int                                items_sent   = 0;
    int                                sender_calm  = 0;
    int                                reader_calm  = 0;

    fast_tree_key_search_unit #(
        .TOP_LEVELS   (TOP_LEVELS),
        .LOWER_LEVELS (LOWER_LEVELS),
        .STORE_DEPTH  (STORE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // An impossible pattern marks the walk as broken and carries on as child 3.
    // The base of the first group met that holds an unwritten word goes to gap.
    function automatic int pick_child(input logic signed [ftks_pkg::KEY_W-1:0] key,
                                      input int base, inout bit broken, inout int gap);
        logic [2:0] pattern;
        for (int i = 0; i < 3; i++)
        begin
            pattern[i] = key > tree_shadow[(base + i) % STORE_DEPTH];
            if (!tree_written[(base + i) % STORE_DEPTH] && (gap < 0))
                gap = base;
        end
        case (pattern)
            BELOW_ALL:    return 0;
            ABOVE_LEFT:   return 1;
            ABOVE_MEDIAN: return 2;
            ABOVE_ALL:    return 3;
            default:
            begin
                broken = 1'b1;
                return 3;
            end
        endcase
    endfunction

    function automatic int walk_page(input logic signed [ftks_pkg::KEY_W-1:0] key,
                                     input int base, input int levels,
                                     inout bit broken, inout int gap);
        int page;
        int node;
        int blk;
        int first;
        int second;
        page = 0;
        node = 0;
        for (int l = 1; l <= levels; l++)
        begin
            blk    = base + page + node * ftks_pkg::BLOCK_WORDS;
            first  = pick_child(key, blk, broken, gap);
            second = pick_child(key, blk + 3 + 3 * first, broken, gap);
            node   = node * 16 + first * 4 + second;
            page  += 1 << (4 * l);
        end
        return node;
    endfunction

    function automatic ftks_pkg::rsp_item_t find_leaf(
        input logic signed [ftks_pkg::KEY_W-1:0] key);
        bit                  broken;
        int                  gap;
        int                  top_node;
        int                  low_node;
        logic [31:0]         leaf;
        ftks_pkg::rsp_item_t res;
        broken   = 1'b0;
        gap      = -1;
        top_node = walk_page(key, 0, TOP_LEVELS, broken, gap);
        low_node = walk_page(key, TOP_PAGE_WORDS + top_node * LOWER_PAGE_WORDS,
                             LOWER_LEVELS, broken, gap);
        leaf           = (top_node << (4 * LOWER_LEVELS)) | low_node;
        res.leaf_index = broken ? '0 : leaf[ftks_pkg::LEAF_W-1:0];
        res.fault      = broken;
        return res;
    endfunction

    // Base word of the first group on the key's path that is not fully
    // written, or -1 when the whole path has been written.
    function automatic int path_gap(input logic signed [ftks_pkg::KEY_W-1:0] key);
        bit broken;
        int gap;
        int top_node;
        broken   = 1'b0;
        gap      = -1;
        top_node = walk_page(key, 0, TOP_LEVELS, broken, gap);
        void'(walk_page(key, TOP_PAGE_WORDS + top_node * LOWER_PAGE_WORDS,
                        LOWER_LEVELS, broken, gap));
        return gap;
    endfunction

    function automatic ftks_pkg::req_item_t make_write(
        input int addr, input logic signed [ftks_pkg::KEY_W-1:0] value);
        ftks_pkg::req_item_t item;
        item.command      = ftks_pkg::CMD_WRITE;
        item.word_address = ftks_pkg::ADDR_W'(addr);
        item.word_value   = value;
        item.query_key    = $urandom;
        return item;
    endfunction

    function automatic ftks_pkg::req_item_t make_search(
        input logic signed [ftks_pkg::KEY_W-1:0] key);
        ftks_pkg::req_item_t item;
        item.command      = ftks_pkg::CMD_SEARCH;
        item.word_address = ftks_pkg::ADDR_W'($urandom);
        item.word_value   = $urandom;
        item.query_key    = key;
        return item;
    endfunction

    // Offers one item after a random gap and records its effect once accepted.
    task automatic send_item(input ftks_pkg::req_item_t item, input bit typed = 1'b0,
                             input ftks_pkg::rsp_item_t typed_leaf = '0);
        int gap;
        if (sender_calm > 0)
        begin
            gap = 0;
            sender_calm--;
        end
        else
        begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 24) == 0)
                sender_calm = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        items_sent++;
        if (item.command == ftks_pkg::CMD_WRITE)
        begin
            if (item.word_address < STORE_DEPTH)
            begin
                tree_shadow[item.word_address]  = item.word_value;
                tree_written[item.word_address] = 1'b1;
            end
        end
        else
            pending_leaves.insert(pending_leaves.size(),
                                  typed ? typed_leaf : find_leaf(item.query_key));
    endtask

    // Extremes are kept out of sorted groups so that the smallest and largest
    // keys run straight down the outermost children.
    task automatic write_sorted_group(input int base);
        logic signed [ftks_pkg::KEY_W-1:0] v [3];
        logic signed [ftks_pkg::KEY_W-1:0] t;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = $urandom;
            if (v[i] == KEY_MAX)
                v[i] = v[i] - 1;
            else if (v[i] == KEY_MIN)
                v[i] = v[i] + 1;
        end
        if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
        if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
        if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
        send_item(make_write(base, v[1]));
        send_item(make_write(base + 1, v[0]));
        send_item(make_write(base + 2, v[2]));
    endtask

    // Every group that the search will read is written before it is offered.
    task automatic send_search(input logic signed [ftks_pkg::KEY_W-1:0] key,
                               input bit typed = 1'b0,
                               input ftks_pkg::rsp_item_t typed_leaf = '0);
        int gap;
        gap = path_gap(key);
        while (gap >= 0)
        begin
            write_sorted_group(gap);
            gap = path_gap(key);
        end
        send_item(make_search(key), typed, typed_leaf);
    endtask

    initial
    begin
        probe_row_t                        row;
        ftks_pkg::rsp_item_t               typed_leaf;
        int                                pick;
        int                                blk;
        logic signed [ftks_pkg::KEY_W-1:0] key;

        for (int i = 0; i < STORE_DEPTH; i++)
            tree_shadow[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(PROBES); i++)
        begin
            row = PROBES[i];
            if (row.command == ftks_pkg::CMD_WRITE)
                send_item(make_write(row.addr, row.value));
            else
            begin
                typed_leaf.leaf_index = row.leaf;
                typed_leaf.fault      = row.fault;
                send_search(row.value, row.typed, typed_leaf);
            end
        end

        while (items_sent < ITEM_COUNT)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                case ($urandom_range(0, 7))
                    0, 1, 2: key = $urandom;
                    3, 4:    key = tree_shadow[$urandom_range(0, TREE_WORDS - 1)];
                    5:       key = tree_shadow[$urandom_range(0, TREE_WORDS - 1)] + 1;
                    6:       key = tree_shadow[$urandom_range(0, TREE_WORDS - 1)] - 1;
                    default: key = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
                endcase
                send_search(key);
            end
            else if (pick < 92)
            begin
                // At least half the rewrites go to the top page, where they affect most searches.
                if ($urandom_range(0, 1) == 0)
                    blk = $urandom_range(0, TOP_PAGE_WORDS / ftks_pkg::BLOCK_WORDS - 1);
                else
                    blk = $urandom_range(0, TREE_WORDS / ftks_pkg::BLOCK_WORDS - 1);
                write_sorted_group(blk * ftks_pkg::BLOCK_WORDS + 3 * $urandom_range(0, 4));
            end
            else
            begin
                // A stray word can leave a group unsorted and so cause faults.
                if ($urandom_range(0, 1) == 0)
                    send_item(make_write($urandom_range(0, TOP_PAGE_WORDS - 1), $urandom));
                else
                    send_item(make_write($urandom_range(0, STORE_DEPTH - 1), $urandom));
            end
        end
        req_valid <= 1'b0;

        while (pending_leaves.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        int                  stall;
        ftks_pkg::rsp_item_t want;

        wait (rst_n === 1'b1);
        forever
        begin
            if (leaves_seen == HOLD_AFTER)
                stall = HOLD_CYCLES;
            else if (reader_calm > 0)
            begin
                stall = 0;
                reader_calm--;
            end
            else
            begin
                stall = $urandom_range(0, 13);
                if ($urandom_range(0, 24) == 0)
                    reader_calm = $urandom_range(8, 40);
            end
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            leaves_seen++;
            if (pending_leaves.size() == 0)
            begin
                $error("result with no search outstanding: leaf_index %0d, fault %0b",
                       rsp.leaf_index, rsp.fault);
                fails++;
            end
            else
            begin
                want = pending_leaves.pop_front();
                if (rsp.leaf_index !== want.leaf_index)
                begin
                    $error("leaf_index: expected %0d, got %0d", want.leaf_index,
                           rsp.leaf_index);
                    fails++;
                end
                if (rsp.fault !== want.fault)
                begin
                    $error("fault: expected %0b, got %0b", want.fault, rsp.fault);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/ftks_pkg.sv
src/ftks_tree_store.sv
src/ftks_node_cmp.sv
src/fast_tree_key_search_unit.sv
test/tb.sv
